// File: hdl/sha1sh_pkg.sv
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Shared types, constants and round functions of the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

	localparam int BLOCK_BYTES  = 64;
	localparam int BLOCK_WORDS  = BLOCK_BYTES / 4;
	localparam int DIGEST_WORDS = 5;
	localparam int ROUNDS       = 80;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [31:0] PAD_MARK = 32'h80000000;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	localparam logic [31:0] K_0 = 32'h5a827999;
	localparam logic [31:0] K_1 = 32'h6ed9eba1;
	localparam logic [31:0] K_2 = 32'h8f1bbcdc;
	localparam logic [31:0] K_3 = 32'hca62c1d6;

	// One classified word for the compression side.
	typedef struct packed {
		logic [31:0] word;      // message word, already masked and marked
		logic [5:0]  add_bits;  // bits this word adds to the message length
		logic        last;      // final word of the message
		logic        mark_next; // final word was full, the pad mark follows
	} cmd_t;

	function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
	                                        input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (rnd < 7'd40) begin
			f = b ^ c ^ d;
		end else if (rnd < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20) begin
			k = K_0;
		end else if (rnd < 7'd40) begin
			k = K_1;
		end else if (rnd < 7'd60) begin
			k = K_2;
		end else begin
			k = K_3;
		end
		return k;
	endfunction

endpackage

// File: hdl/sha1sh_front.sv
// ----------------------------------------------------------------------------
// sha1sh_front
// Input stage: takes words, masks short final words and places the pad mark.
// ----------------------------------------------------------------------------
module sha1sh_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [31:0]       data_word,
	input  logic [2:0]        valid_bytes,
	input  logic              end_of_message,
	input  logic              q_full,
	output logic              cmd_valid,
	output sha1sh_pkg::cmd_t  cmd
);

	logic             valid_s1;
	sha1sh_pkg::cmd_t cmd_s1;
	sha1sh_pkg::cmd_t cmd_next;
	logic [2:0]       nbytes;
	logic             accept;

	assign full      = valid_s1 & q_full;
	assign accept    = push & ~full;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_comb begin
		nbytes             = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
		cmd_next.last      = end_of_message;
		cmd_next.mark_next = 1'b0;
		cmd_next.add_bits  = 6'd32;
		cmd_next.word      = data_word;
		if (end_of_message) begin
			cmd_next.add_bits = {nbytes, 3'b000};
			case (nbytes)
				3'd0: cmd_next.word = sha1sh_pkg::PAD_MARK;
				3'd1: cmd_next.word = {data_word[31:24], sha1sh_pkg::PAD_BYTE, 16'h0000};
				3'd2: cmd_next.word = {data_word[31:16], sha1sh_pkg::PAD_BYTE, 8'h00};
				3'd3: cmd_next.word = {data_word[31:8], sha1sh_pkg::PAD_BYTE};
				default: begin
					cmd_next.word      = data_word;
					cmd_next.mark_next = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_next;
		end
	end

endmodule

// File: hdl/sha1sh_fifo.sv
// ----------------------------------------------------------------------------
// sha1sh_fifo
// Short queue of classified words between the input and compression sides.
// ----------------------------------------------------------------------------
module sha1sh_fifo #(
	parameter int DEPTH = sha1sh_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  sha1sh_pkg::cmd_t  wr_data,
	output logic              full,
	input  logic              rd_en,
	output sha1sh_pkg::cmd_t  rd_data,
	output logic              empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sha1sh_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: hdl/sha1sh_back.sv
// ----------------------------------------------------------------------------
// sha1sh_back
// Compression side: block gathering, padding, 80 rounds and digest output.
// ----------------------------------------------------------------------------
module sha1sh_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  sha1sh_pkg::cmd_t  q_data,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_index,
	output logic              last_word
);

	localparam int BW = sha1sh_pkg::BLOCK_WORDS;
	localparam int DW = sha1sh_pkg::DIGEST_WORDS;
	localparam int NW = $clog2(BW);

	typedef enum logic [3:0] {
		ST_GATHER = 4'b0001,
		ST_PAD    = 4'b0010,
		ST_ROUND  = 4'b0100,
		ST_ADD    = 4'b1000
	} state_t;

	state_t        state_q;
	logic [31:0]   w_q     [BW];
	logic [31:0]   vars_q  [5];
	logic [31:0]   chain_q [DW];
	logic [31:0]   dig_q   [DW];
	logic [NW-1:0] cnt_q;
	logic [6:0]    round_q;
	logic [63:0]   bitlen_q;
	logic          pad_q;
	logic          mark_q;
	logic          len_ok_q;
	logic          final_q;
	logic          out_busy_q;
	logic [2:0]    out_idx_q;

	logic          wr_en;
	logic [31:0]   wr_word;
	logic          blk_end;
	logic [31:0]   f_val;
	logic [31:0]   t_val;
	logic [31:0]   w_new;
	logic          out_take;

	assign q_pop       = (state_q == ST_GATHER) & ~q_empty;
	assign blk_end     = (cnt_q == NW'(BW - 1));
	assign empty       = ~out_busy_q;
	assign out_take    = pop & out_busy_q;
	assign digest_word = dig_q[0];
	assign word_index  = out_idx_q;
	assign last_word   = (out_idx_q == 3'(DW - 1));

	// Word that enters the block this cycle, from the queue or from padding.
	always_comb begin
		wr_en   = 1'b0;
		wr_word = q_data.word;
		case (state_q)
			ST_GATHER: begin
				wr_en = ~q_empty;
			end
			ST_PAD: begin
				wr_en = 1'b1;
				if (mark_q) begin
					wr_word = sha1sh_pkg::PAD_MARK;
				end else if (len_ok_q && cnt_q == NW'(BW - 2)) begin
					wr_word = bitlen_q[63:32];
				end else if (len_ok_q && blk_end) begin
					wr_word = bitlen_q[31:0];
				end else begin
					wr_word = '0;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		f_val = sha1sh_pkg::round_f(round_q, vars_q[1], vars_q[2], vars_q[3]);
		t_val = {vars_q[0][26:0], vars_q[0][31:27]} + f_val + vars_q[4]
		        + sha1sh_pkg::round_k(round_q) + w_q[0];
		w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_new = {w_new[30:0], w_new[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_GATHER;
			cnt_q      <= '0;
			round_q    <= '0;
			bitlen_q   <= '0;
			pad_q      <= 1'b0;
			mark_q     <= 1'b0;
			len_ok_q   <= 1'b0;
			final_q    <= 1'b0;
			out_busy_q <= 1'b0;
			out_idx_q  <= '0;
			for (int i = 0; i < DW; i++) begin
				chain_q[i] <= sha1sh_pkg::H_INIT[i];
			end
		end else begin
			if (out_take) begin
				if (last_word) begin
					out_busy_q <= 1'b0;
				end
				out_idx_q <= out_idx_q + 3'd1;
			end
			if (wr_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			case (state_q)
				ST_GATHER: begin
					if (wr_en) begin
						bitlen_q <= bitlen_q + 64'(q_data.add_bits);
						if (q_data.last) begin
							pad_q    <= 1'b1;
							mark_q   <= q_data.mark_next;
							len_ok_q <= ~q_data.mark_next & (cnt_q < NW'(BW - 2));
							state_q  <= ST_PAD;
						end
						if (blk_end) begin
							state_q <= ST_ROUND;
						end
					end
				end
				ST_PAD: begin
					if (mark_q) begin
						mark_q   <= 1'b0;
						len_ok_q <= (cnt_q < NW'(BW - 2));
					end else if (len_ok_q && blk_end) begin
						final_q <= 1'b1;
					end
					if (blk_end) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (round_q == 7'(sha1sh_pkg::ROUNDS - 1)) begin
						round_q <= '0;
						state_q <= ST_ADD;
					end else begin
						round_q <= round_q + 7'd1;
					end
				end
				ST_ADD: begin
					if (final_q) begin
						// The digest waits here until the previous one has drained.
						if (!out_busy_q) begin
							out_busy_q <= 1'b1;
							out_idx_q  <= '0;
							bitlen_q   <= '0;
							pad_q      <= 1'b0;
							len_ok_q   <= 1'b0;
							final_q    <= 1'b0;
							state_q    <= ST_GATHER;
							for (int i = 0; i < DW; i++) begin
								chain_q[i] <= sha1sh_pkg::H_INIT[i];
							end
						end
					end else begin
						for (int i = 0; i < DW; i++) begin
							chain_q[i] <= chain_q[i] + vars_q[i];
						end
						if (pad_q) begin
							len_ok_q <= 1'b1;
							state_q  <= ST_PAD;
						end else begin
							state_q <= ST_GATHER;
						end
					end
				end
				default: begin
					state_q <= ST_GATHER;
				end
			endcase
		end
	end

	// Datapath: schedule window, working variables and digest shift line.
	always_ff @(posedge clk) begin
		if (wr_en || state_q == ST_ROUND) begin
			for (int i = 0; i < BW - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BW - 1] <= (state_q == ST_ROUND) ? w_new : wr_word;
		end
		if (wr_en && blk_end) begin
			for (int i = 0; i < 5; i++) begin
				vars_q[i] <= chain_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			vars_q[4] <= vars_q[3];
			vars_q[3] <= vars_q[2];
			vars_q[2] <= {vars_q[1][1:0], vars_q[1][31:2]};
			vars_q[1] <= vars_q[0];
			vars_q[0] <= t_val;
		end
		if (state_q == ST_ADD && final_q && !out_busy_q) begin
			for (int i = 0; i < DW; i++) begin
				dig_q[i] <= chain_q[i] + vars_q[i];
			end
		end else if (out_take) begin
			for (int i = 0; i < DW - 1; i++) begin
				dig_q[i] <= dig_q[i + 1];
			end
		end
	end

endmodule

// File: hdl/sha1_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher_core
// SHA-1 over a byte message streamed in as big-endian 32-bit words.
// ----------------------------------------------------------------------------
// Words enter through a queue-style port (push/full) and the 160-bit digest
// leaves as five words, h0 first, through a second queue-style port
// (empty/pop). Every word but the last carries four bytes; the word with
// end_of_message set carries zero to four bytes in its high-order positions
// and closes the message, after which the hasher pads, finishes and starts
// the next message from the initial chaining value. A block of sixteen
// words is shifted into the schedule window, run through eighty rounds
// in the single round unit (one round per cycle) and then folded into the
// chaining value. Closing a message fills the rest of the current block
// with padding words at one per cycle before its rounds and fold; when the
// length no longer fits in that block, it takes one more block of sixteen
// padding words and another pass of rounds and fold. A finished digest
// sits in its own shift register, so the next message can stream in while
// the digest is drained; a second digest waits until the first has been
// fully popped. Input words are buffered in a small queue ahead of the
// round unit, and full rises when it and the input stage are both
// occupied.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_core #(
	parameter int QUEUE_DEPTH = sha1sh_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] data_word,
	input  logic [2:0]  valid_bytes,
	input  logic        end_of_message,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	// Classified word from the input stage toward the queue.
	sha1sh_pkg::cmd_t front_cmd;
	logic             front_valid;

	// Queue toward the compression side.
	sha1sh_pkg::cmd_t q_data;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;

	// The input stage masks unused bytes and inserts the pad mark.
	sha1sh_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_word      (data_word),
		.valid_bytes    (valid_bytes),
		.end_of_message (end_of_message),
		.q_full         (q_full),
		.cmd_valid      (front_valid),
		.cmd            (front_cmd)
	);

	// The queue lets input keep flowing while a block is being compressed.
	sha1sh_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid),
		.wr_data (front_cmd),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	// The compression side gathers blocks, pads, runs rounds and emits digests.
	sha1sh_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule

// File: hdl/sha1sh_checker.sv
// ----------------------------------------------------------------------------
// sha1sh_checker
// Port-level checks on the digest output sequence of the stream hasher.
// ----------------------------------------------------------------------------
module sha1sh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// The last flag marks exactly the fifth digest word.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last_word == (word_index == 3'd4)))
		else $error("last_word does not match word_index");

	// A digest drains without gaps, one index after the other.
	a_next_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_word) |=>
		(!empty && word_index == $past(word_index) + 3'd1))
		else $error("digest word missing or out of order");

	// A new digest always starts with h0.
	a_first_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && last_word) |=> (empty || word_index == 3'd0))
		else $error("digest does not start at word 0");

	// A word that is not taken stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=>
		(!empty && $stable(digest_word) && $stable(word_index)))
		else $error("stalled digest word changed");

endmodule

bind sha1_stream_hasher_core sha1sh_checker u_sha1sh_checker (.*);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SHA-1 stream hasher core.
// ----------------------------------------------------------------------------
// Messages are queued up front as lists of words, then fed to the core by a
// clocked driver. Each word is folded into a local SHA-1 model as the core
// accepts it. A message's closing word makes the model pad and finish the
// message and queue the five digest words it expects. A clocked monitor pops
// digest words and checks each one against the oldest expectation. Both
// sides idle in random bursts. The receiver once holds off long enough for
// the core to back up and raise full. The sender once waits for all digests
// to drain.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIGEST_WORDS = sha1sh_pkg::DIGEST_WORDS;
	localparam int BLOCK_WORDS  = sha1sh_pkg::BLOCK_WORDS;

	// Byte counts and pad words used by the local model.
	localparam logic [2:0]  FULL_BYTES = 3'd4;
	localparam logic [31:0] MARK_WORD  = 32'h80000000;
	localparam logic [31:0] MARK_BYTE  = 32'h00000080;
	localparam int          LAST_INDEX = DIGEST_WORDS - 1;

	// Standard SHA-1 starting chain and round constants, kept local so that
	// the model does not lean on the design's own package values.
	localparam logic [31:0] CHAIN_START [5] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};
	localparam logic [31:0] ROUND_K [4] = '{
		32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
	};

	// Run control.
	localparam int RAND_ITEMS  = 420;    // stop queuing messages past this
	localparam int TAIL_ITEMS  = 60;     // no idling once this few words remain
	localparam int HOLD_AT     = 200;    // accepted words before the long hold
	localparam int HOLD_CYCLES = 900;    // length of the receiver's long hold
	localparam int SETTLE      = 400;    // quiet cycles after the last digest
	localparam int CYCLE_LIMIT = 400000; // hard stop for a hung core

	typedef struct {
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic        eom;
		bit          drain_first; // wait for every digest before offering
	} msg_item_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        push           = 1'b0;
	logic [31:0] data_word      = '0;
	logic [2:0]  valid_bytes    = '0;
	logic        end_of_message = 1'b0;
	logic        pop            = 1'b0;
	logic        full;
	logic        empty;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	msg_item_t   pend[$];        // words waiting to be offered
	digest_t     digest_due[$];  // digest words the model predicts, oldest first

	int unsigned cycle_count = 0;
	int unsigned words_taken = 0;
	int unsigned fail_count  = 0;

	// Model state: chaining value, block buffer, fill level and bit length.
	logic [31:0] sha_chain [5];
	logic [31:0] sha_block [16];
	int          sha_fill;
	logic [63:0] sha_bits;

	always #2ns clk = ~clk;

	sha1_stream_hasher_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_word      (data_word),
		.valid_bytes    (valid_bytes),
		.end_of_message (end_of_message),
		.empty          (empty),
		.pop            (pop),
		.digest_word    (digest_word),
		.word_index     (word_index),
		.last_word      (last_word)
	);

	// ------------------------------------------------------------------------
	// SHA-1 model
	// ------------------------------------------------------------------------

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void sha_restart();
		for (int i = 0; i < 5; i++) begin
			sha_chain[i] = CHAIN_START[i];
		end
		sha_fill = 0;
		sha_bits = '0;
	endfunction

	// One 80-round compression of the sixteen buffered words into the chain.
	function automatic void sha_compress();
		logic [31:0] sched [80];
		logic [31:0] a, b, c, d, e, f, t;
		int          grp;
		for (int i = 0; i < 16; i++) begin
			sched[i] = sha_block[i];
		end
		for (int i = 16; i < 80; i++) begin
			sched[i] = rotl(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
		end
		a = sha_chain[0];
		b = sha_chain[1];
		c = sha_chain[2];
		d = sha_chain[3];
		e = sha_chain[4];
		for (int r = 0; r < 80; r++) begin
			grp = r / 20;
			case (grp)
				0: begin
					f = (b & c) | (~b & d);
				end
				2: begin
					f = (b & c) | (b & d) | (c & d);
				end
				default: begin
					f = b ^ c ^ d;
				end
			endcase
			t = rotl(a, 5) + f + e + ROUND_K[grp] + sched[r];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		sha_chain[0] += a;
		sha_chain[1] += b;
		sha_chain[2] += c;
		sha_chain[3] += d;
		sha_chain[4] += e;
	endfunction

	function automatic void sha_absorb(input logic [31:0] w);
		sha_block[sha_fill] = w;
		sha_fill++;
		if (sha_fill == BLOCK_WORDS) begin
			sha_compress();
			sha_fill = 0;
		end
	endfunction

	// Closing word: mask the unused low bytes, place the 0x80 marker, zero
	// fill, append the 64-bit length, then queue the five digest words.
	function automatic void sha_close(input logic [31:0] data, input logic [2:0] nb_in);
		logic [2:0]  nb;
		logic [31:0] keep;
		logic [31:0] mark;
		digest_t     dw;
		nb = (nb_in > FULL_BYTES) ? FULL_BYTES : nb_in;
		sha_bits += 64'(nb) * 64'd8;
		if (nb == FULL_BYTES) begin
			sha_absorb(data);
			sha_absorb(MARK_WORD);
		end else begin
			keep = (nb == 3'd0) ? 32'h0 : (32'hffffffff << (32 - 8 * int'(nb)));
			mark = MARK_BYTE << (24 - 8 * int'(nb));
			sha_absorb((data & keep) | mark);
		end
		// No room left for the length: finish this block with zeros first.
		if (sha_fill > BLOCK_WORDS - 2) begin
			while (sha_fill != 0) begin
				sha_absorb(32'h0);
			end
		end
		while (sha_fill < BLOCK_WORDS - 2) begin
			sha_absorb(32'h0);
		end
		sha_absorb(sha_bits[63:32]);
		sha_absorb(sha_bits[31:0]);
		for (int i = 0; i < DIGEST_WORDS; i++) begin
			dw.word  = sha_chain[i];
			dw.index = 3'(i);
			dw.last  = (i == LAST_INDEX);
			digest_due.push_back(dw);
		end
		sha_restart();
	endfunction

	// Every accepted word goes through here.
	function automatic void sha_take(input logic [31:0] data, input logic [2:0] nb,
	                                 input logic eom);
		if (eom) begin
			sha_close(data, nb);
		end else begin
			// Non-final words always count as four bytes.
			sha_bits += 64'd32;
			sha_absorb(data);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	// Mostly random data, with all-zero and all-one words mixed in.
	function automatic logic [31:0] rand_word();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			return 32'h0;
		end else if (pick == 1) begin
			return 32'hffffffff;
		end
		return $urandom;
	endfunction

	// A message of n_body full words followed by its closing word. The
	// valid_bytes of the body words is random, since the core ignores it.
	task automatic add_message(input int n_body, input logic [31:0] last_data,
	                           input logic [2:0] last_bytes, input bit drain);
		msg_item_t it;
		for (int i = 0; i < n_body; i++) begin
			it.data        = rand_word();
			it.nbytes      = 3'($urandom_range(0, 7));
			it.eom         = 1'b0;
			it.drain_first = drain && (i == 0);
			pend.push_back(it);
		end
		it.data        = last_data;
		it.nbytes      = last_bytes;
		it.eom         = 1'b1;
		it.drain_first = drain && (n_body == 0);
		pend.push_back(it);
	endtask

	// Idling is switched off near the end of the run and during periodic
	// calm windows, so the core also sees long unbroken streams.
	function automatic bit calm();
		return (pend.size() < TAIL_ITEMS) || ((cycle_count / 700) % 4 == 0);
	endfunction

	initial begin
		int  n_body;
		int  pick;
		bit  drained;
		logic [2:0] vb;

		sha_restart();

		// Directed part: the empty message with its data fully masked, one
		// closing word of each length (the "abc" vector among them), valid
		// byte counts above four that saturate, and a 56-byte message whose
		// padding spills into an extra block, with random ignored valid_bytes
		// codes on its body words.
		add_message(0, 32'hffffffff, 3'd0, 1'b0);
		add_message(0, 32'h616263ff, 3'd3, 1'b0);
		add_message(0, 32'hffffffff, 3'd1, 1'b0);
		add_message(0, 32'h00000000, 3'd2, 1'b0);
		add_message(0, 32'hdeadbeef, 3'd4, 1'b0);
		add_message(0, 32'h12345678, 3'd5, 1'b0);
		add_message(0, 32'hffffffff, 3'd6, 1'b0);
		add_message(0, 32'h0f0f0f0f, 3'd7, 1'b0);
		add_message(13, 32'hffffffff, 3'd4, 1'b0);

		// Random part: mostly short messages so digests come often, some
		// spanning a few blocks, and one message that waits for a full drain.
		drained = 1'b0;
		while (pend.size() < RAND_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				n_body = $urandom_range(0, 6);
			end else if (pick < 19) begin
				n_body = $urandom_range(7, 20);
			end else begin
				n_body = $urandom_range(21, 40);
			end
			pick = $urandom_range(0, 9);
			vb   = (pick > 7) ? FULL_BYTES : 3'(pick);
			add_message(n_body, rand_word(), vb, !drained && pend.size() > 260);
			if (pend.size() > 260) begin
				drained = 1'b1;
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pend.size() != 0 || push || digest_due.size() != 0) begin
			@(posedge clk);
		end
		// Let the core settle so that any stray digest word still shows up.
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driver: offers queued words on push/full. A word held against full
	// stays on the port untouched until the core takes it.
	// ------------------------------------------------------------------------
	int gap_left = 0;

	always @(posedge clk) begin
		msg_item_t nxt;
		if (arst_n) begin
			if (push && !full) begin
				sha_take(data_word, valid_bytes, end_of_message);
				words_taken++;
			end
			if (!(push && full)) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (pend.size() == 0) begin
					push <= 1'b0;
				end else if (pend[0].drain_first && digest_due.size() != 0) begin
					// Hold the sender until every pending digest has been read.
					push <= 1'b0;
				end else if (!calm() && $urandom_range(0, 4) == 0) begin
					gap_left = $urandom_range(1, 12) - 1;
					push <= 1'b0;
				end else begin
					nxt = pend.pop_front();
					data_word      <= nxt.data;
					valid_bytes    <= nxt.nbytes;
					end_of_message <= nxt.eom;
					push           <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: pops digest words and checks them in order. Once, partway
	// through, it stops popping for a long stretch so the finished digest
	// blocks the core and the input side backs up to full.
	// ------------------------------------------------------------------------
	int  stall_left = 0;
	int  hold_left  = 0;
	bit  hold_done  = 1'b0;

	always @(posedge clk) begin
		digest_t due;
		if (arst_n) begin
			if (pop && !empty) begin
				if (digest_due.size() == 0) begin
					$error("unexpected digest word: digest_word=%h word_index=%0d",
					       digest_word, word_index);
					fail_count++;
				end else begin
					due = digest_due.pop_front();
					if (digest_word !== due.word) begin
						$error("digest_word: expected %h, got %h", due.word, digest_word);
						fail_count++;
					end
					if (word_index !== due.index) begin
						$error("word_index: expected %0d, got %0d", due.index, word_index);
						fail_count++;
					end
					if (last_word !== due.last) begin
						$error("last_word: expected %0b, got %0b", due.last, last_word);
						fail_count++;
					end
				end
			end
			if (!hold_done && words_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (!calm() && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog against a core that stops responding.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule
